>>> design/assert_macros.svh
// Assertion macros used by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> design/mphq_pkg.sv
// Types, constants and codes of the max-priority heap queue.
`timescale 1ns / 1ps

package mphq_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 8;
   localparam int TAG_BITS   = 32;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int CODE_BITS  = 2;

   typedef enum logic [CODE_BITS-1:0] {
      CODE_INSERTED  = 2'd0,
      CODE_FULL      = 2'd1,
      CODE_EXTRACTED = 2'd2,
      CODE_EMPTY     = 2'd3
   } code_type;

   typedef enum logic {
      CMD_INSERT  = 1'b0,
      CMD_EXTRACT = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP,
      ST_EX_ROOT,
      ST_EX_LAST,
      ST_DN_ISSUE,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_WR_HELD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } req_type;

   typedef struct packed {
      code_type              code;
      logic [TAG_BITS-1:0]   tag;
      logic [COUNT_BITS-1:0] fill;
   } rsp_type;

endpackage

>>> design/mphq_req_if.sv
// Request channel of the heap queue: command, priority and tag.
`timescale 1ns / 1ps

interface mphq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [mphq_pkg::KEY_BITS-1:0] priority_req;
   logic [mphq_pkg::TAG_BITS-1:0] record_tag;

   modport source (output valid, cmd, priority_req, record_tag, input ready);
   modport sink (input valid, cmd, priority_req, record_tag, output ready);
endinterface

>>> design/mphq_rsp_if.sv
// Response channel of the heap queue: result code, tag and fill count.
`timescale 1ns / 1ps

interface mphq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mphq_pkg::CODE_BITS-1:0]  result_code;
   logic [mphq_pkg::TAG_BITS-1:0]   out_tag;
   logic [mphq_pkg::COUNT_BITS-1:0] fill_count;

   modport source (output valid, result_code, out_tag, fill_count, input ready);
   modport sink (input valid, result_code, out_tag, fill_count, output ready);
endinterface

>>> design/mphq_heap.sv
// Heap engine: entry memory, fill count and the sift-up / sift-down sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mphq_heap (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  mphq_pkg::req_type  req_data,
   output logic               req_ready,
   output logic               rsp_valid,
   output mphq_pkg::rsp_type  rsp_data,
   input  logic               rsp_take
);

   localparam int IDX_BITS = mphq_pkg::ADDR_BITS + 2;

   function automatic logic [mphq_pkg::ADDR_BITS-1:0] parent_of(
      input logic [mphq_pkg::ADDR_BITS-1:0] p);
      logic [mphq_pkg::ADDR_BITS-1:0] dec;
      dec = p - 1'b1;
      return dec >> 1;
   endfunction

   mphq_pkg::entry_type heap_mem [mphq_pkg::CAPACITY];

   mphq_pkg::state_type              state_ff, state_in;
   logic [mphq_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [mphq_pkg::ADDR_BITS-1:0]   pos_ff, pos_in;
   mphq_pkg::entry_type              held_ff, held_in;
   mphq_pkg::entry_type              child_ff, child_in;
   mphq_pkg::code_type               code_ff, code_in;
   logic [mphq_pkg::TAG_BITS-1:0]    out_tag_ff, out_tag_in;

   logic [mphq_pkg::ADDR_BITS-1:0]   rd_addr;
   mphq_pkg::entry_type              rd_data_ff;
   logic                             wr_en;
   logic [mphq_pkg::ADDR_BITS-1:0]   wr_addr;
   mphq_pkg::entry_type              wr_data;

   logic [IDX_BITS-1:0]              left_idx, right_idx, count_ext;
   logic [mphq_pkg::ADDR_BITS-1:0]   up_parent, up_grand, ins_parent;
   mphq_pkg::entry_type              left_e;
   logic                             left_win, right_win;
   logic [mphq_pkg::KEY_BITS-1:0]    cand_key;

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mphq_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      held_ff    <= held_in;
      child_ff   <= child_in;
      code_ff    <= code_in;
      out_tag_ff <= out_tag_in;
   end

   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + 1'b1;
   assign count_ext  = {{(IDX_BITS - mphq_pkg::COUNT_BITS){1'b0}}, count_ff};
   assign up_parent  = parent_of(pos_ff);
   assign up_grand   = parent_of(up_parent);
   assign ins_parent = parent_of(count_ff[mphq_pkg::ADDR_BITS-1:0]);

   // Child selection: left wins ties, a child must beat the held entry strictly.
   assign left_e    = (state_ff == mphq_pkg::ST_DN_LEFT) ? rd_data_ff : child_ff;
   assign left_win  = left_e.key > held_ff.key;
   assign cand_key  = left_win ? left_e.key : held_ff.key;
   assign right_win = (state_ff == mphq_pkg::ST_DN_RIGHT) && (rd_data_ff.key > cand_key);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      held_in    = held_ff;
      child_in   = child_ff;
      code_in    = code_ff;
      out_tag_in = out_tag_ff;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = held_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      case (state_ff)
         mphq_pkg::ST_IDLE: begin
            req_ready = !reset;
            if (req_valid) begin
               held_in.key = req_data.key;
               held_in.tag = req_data.tag;
               out_tag_in  = '0;
               if (req_data.cmd == mphq_pkg::CMD_INSERT) begin
                  if (count_ff >= mphq_pkg::COUNT_BITS'(mphq_pkg::CAPACITY)) begin
                     code_in  = mphq_pkg::CODE_FULL;
                     state_in = mphq_pkg::ST_DONE;
                  end else begin
                     code_in  = mphq_pkg::CODE_INSERTED;
                     count_in = count_ff + 1'b1;
                     pos_in   = count_ff[mphq_pkg::ADDR_BITS-1:0];
                     rd_addr  = ins_parent;
                     state_in = (count_ff == '0) ? mphq_pkg::ST_WR_HELD : mphq_pkg::ST_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     code_in  = mphq_pkg::CODE_EMPTY;
                     state_in = mphq_pkg::ST_DONE;
                  end else begin
                     code_in  = mphq_pkg::CODE_EXTRACTED;
                     count_in = count_ff - 1'b1;
                     rd_addr  = '0;
                     state_in = mphq_pkg::ST_EX_ROOT;
                  end
               end
            end
         end

         mphq_pkg::ST_UP: begin
            // Parent entry is in the read register; move it down or settle here.
            wr_en = 1'b1;
            if (held_ff.key > rd_data_ff.key) begin
               wr_data = rd_data_ff;
               pos_in  = up_parent;
               rd_addr = up_grand;
               if (up_parent == '0) begin
                  state_in = mphq_pkg::ST_WR_HELD;
               end
            end else begin
               state_in = mphq_pkg::ST_DONE;
            end
         end

         mphq_pkg::ST_EX_ROOT: begin
            out_tag_in = rd_data_ff.tag;
            rd_addr    = count_ff[mphq_pkg::ADDR_BITS-1:0];
            state_in   = mphq_pkg::ST_EX_LAST;
         end

         mphq_pkg::ST_EX_LAST: begin
            held_in  = rd_data_ff;
            pos_in   = '0;
            state_in = (count_ff == '0) ? mphq_pkg::ST_DONE : mphq_pkg::ST_DN_ISSUE;
         end

         mphq_pkg::ST_DN_ISSUE: begin
            if (left_idx >= count_ext) begin
               wr_en    = 1'b1;
               state_in = mphq_pkg::ST_DONE;
            end else begin
               rd_addr  = left_idx[mphq_pkg::ADDR_BITS-1:0];
               state_in = mphq_pkg::ST_DN_LEFT;
            end
         end

         mphq_pkg::ST_DN_LEFT, mphq_pkg::ST_DN_RIGHT: begin
            if ((state_ff == mphq_pkg::ST_DN_LEFT) && (right_idx < count_ext)) begin
               // Hold the left child and fetch the right one.
               child_in = rd_data_ff;
               rd_addr  = right_idx[mphq_pkg::ADDR_BITS-1:0];
               state_in = mphq_pkg::ST_DN_RIGHT;
            end else begin
               wr_en = 1'b1;
               if (right_win) begin
                  wr_data  = rd_data_ff;
                  pos_in   = right_idx[mphq_pkg::ADDR_BITS-1:0];
                  state_in = mphq_pkg::ST_DN_ISSUE;
               end else if (left_win) begin
                  wr_data  = left_e;
                  pos_in   = left_idx[mphq_pkg::ADDR_BITS-1:0];
                  state_in = mphq_pkg::ST_DN_ISSUE;
               end else begin
                  state_in = mphq_pkg::ST_DONE;
               end
            end
         end

         mphq_pkg::ST_WR_HELD: begin
            wr_en    = 1'b1;
            state_in = mphq_pkg::ST_DONE;
         end

         mphq_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_take) begin
               state_in = mphq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mphq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_data.code = code_ff;
   assign rsp_data.tag  = out_tag_ff;
   assign rsp_data.fill = count_ff;

   `ASSERT_PROP(a_full_at_capacity, clock, reset, (state_ff == mphq_pkg::ST_DONE && code_ff == mphq_pkg::CODE_FULL) |-> (count_ff == mphq_pkg::COUNT_BITS'(mphq_pkg::CAPACITY)), "full code with free space")
   `ASSERT_PROP(a_empty_at_zero, clock, reset, (state_ff == mphq_pkg::ST_DONE && code_ff == mphq_pkg::CODE_EMPTY) |-> (count_ff == '0), "empty code with entries held")
   `ASSERT_NEVER(a_insert_nonzero, clock, reset, state_ff == mphq_pkg::ST_DONE && code_ff == mphq_pkg::CODE_INSERTED && count_ff == '0, "insert left heap empty")
   `ASSERT_PROP(a_accept_busy, clock, reset, (req_valid && req_ready) |=> (state_ff != mphq_pkg::ST_IDLE), "accepted item did not start")
   `ASSERT_PROP(a_count_hold, clock, reset, (state_ff != mphq_pkg::ST_IDLE) |=> $stable(count_ff), "fill count moved while busy")

endmodule

>>> design/max_priority_heap_queue.sv
// Sequencing after acceptance: a full or empty result goes straight to the response; an insert
// climbs one level per step; an extract reads the root and the last entry, ends there if the
// heap is now empty, else descends level by level (two child reads, one write-back) until it settles.
// One item in work at a time; the next is taken in the cycle after its response is registered.
// Synchronous active-high reset empties the heap and clears the sequencer state and response
// valid; the entry memory is not cleared, and entries beyond those live at acceptance are never used.
`timescale 1ns / 1ps

module max_priority_heap_queue (
   input  logic       clock,
   input  logic       reset,
   mphq_req_if.sink   req_bus,
   mphq_rsp_if.source rsp_bus
);

   mphq_pkg::req_type req_data;
   mphq_pkg::rsp_type core_rsp;
   logic              core_rsp_valid;
   logic              core_take;
   logic              core_req_ready;

   logic              rsp_valid_ff, rsp_valid_in;
   mphq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign req_data.cmd = mphq_pkg::cmd_type'(req_bus.cmd);
   assign req_data.key = req_bus.priority_req;
   assign req_data.tag = req_bus.record_tag;
   assign req_bus.ready = core_req_ready;

   mphq_heap u_heap (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_data  (req_data),
      .req_ready (core_req_ready),
      .rsp_valid (core_rsp_valid),
      .rsp_data  (core_rsp),
      .rsp_take  (core_take)
   );

   // Take the heap's response into the response register whenever it is empty or being drained.
   assign core_take = core_rsp_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_data_in  = core_take ? core_rsp : rsp_data_ff;
      rsp_valid_in = core_take || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_code = rsp_data_ff.code;
   assign rsp_bus.out_tag     = rsp_data_ff.tag;
   assign rsp_bus.fill_count  = rsp_data_ff.fill;

endmodule

>>> bench/testbench.sv
// Self-checking testbench of the max-priority heap queue with its own heap predictor.
`timescale 1ns / 1ps

module testbench;
   import mphq_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 3;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;

   // Directed fill: extremes and many equal keys, so ties decide the order.
   localparam logic [16*KEY_BITS-1:0] FILL_KEYS = {
      8'd0, 8'd255, 8'd7, 8'd7, 8'd7, 8'd255, 8'd128, 8'd1,
      8'd7, 8'd0, 8'd200, 8'd7, 8'd254, 8'd127, 8'd7, 8'd255
   };

   logic clock;
   logic reset;

   mphq_req_if req_ch ();
   mphq_rsp_if rsp_ch ();

   max_priority_heap_queue u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // Predicted heap contents
   logic [KEY_BITS-1:0] heap_key [CAPACITY];
   logic [TAG_BITS-1:0] heap_tag [CAPACITY];
   int                  heap_size;
   rsp_type             expected_rsps [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int items_sent;
   int rsps_seen;
   int fail_count;
   int n_inserted;
   int n_full;
   int n_extracted;
   int n_empty;

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   function automatic void swap_entries(input int a, input int b);
      logic [KEY_BITS-1:0] k;
      logic [TAG_BITS-1:0] t;
      k = heap_key[a];
      t = heap_tag[a];
      heap_key[a] = heap_key[b];
      heap_tag[a] = heap_tag[b];
      heap_key[b] = k;
      heap_tag[b] = t;
   endfunction

   // Apply one request to the predicted heap and return the response it yields.
   function automatic rsp_type heap_apply(input cmd_type cmd, input logic [KEY_BITS-1:0] key,
                                          input logic [TAG_BITS-1:0] tag);
      rsp_type r;
      int      pos;
      int      parent;
      int      left;
      int      right;
      int      best;
      bit      done;
      r.code = CODE_INSERTED;
      r.tag  = '0;
      if (cmd == CMD_INSERT) begin
         if (heap_size >= CAPACITY) begin
            r.code = CODE_FULL;
            n_full++;
         end else begin
            pos = heap_size;
            heap_key[pos] = key;
            heap_tag[pos] = tag;
            heap_size++;
            done = 1'b0;
            // climb only while strictly greater than the parent
            while (pos > 0 && !done) begin
               parent = (pos - 1) / 2;
               if (heap_key[pos] <= heap_key[parent]) begin
                  done = 1'b1;
               end else begin
                  swap_entries(pos, parent);
                  pos = parent;
               end
            end
            r.code = CODE_INSERTED;
            n_inserted++;
         end
      end else begin
         if (heap_size == 0) begin
            r.code = CODE_EMPTY;
            n_empty++;
         end else begin
            r.code = CODE_EXTRACTED;
            r.tag  = heap_tag[0];
            heap_size--;
            heap_key[0] = heap_key[heap_size];
            heap_tag[0] = heap_tag[heap_size];
            pos  = 0;
            done = 1'b0;
            // left child wins ties, a child must be strictly greater to move up
            while (!done) begin
               left  = 2 * pos + 1;
               right = 2 * pos + 2;
               best  = pos;
               if (left < heap_size && heap_key[left] > heap_key[best]) best = left;
               if (right < heap_size && heap_key[right] > heap_key[best]) best = right;
               if (best == pos) begin
                  done = 1'b1;
               end else begin
                  swap_entries(pos, best);
                  pos = best;
               end
            end
            n_extracted++;
         end
      end
      r.fill = COUNT_BITS'(heap_size);
      return r;
   endfunction

   // Offer one item, idling first at the current rate; predict once accepted.
   task automatic send_item(input cmd_type cmd, input logic [KEY_BITS-1:0] key,
                            input logic [TAG_BITS-1:0] tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid        <= 1'b0;
         req_ch.cmd          <= 1'($urandom_range(1));
         req_ch.priority_req <= KEY_BITS'($urandom);
         req_ch.record_tag   <= $urandom;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.priority_req <= key;
      req_ch.record_tag   <= tag;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsps.push_back(heap_apply(cmd, key, tag));
      items_sent++;
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   // Response side: check each accepted item, then pick the next ready value.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            rsps_seen++;
            if (expected_rsps.size() == 0) begin
               log_failure($sformatf("response %0d arrived with none expected: code %0d tag %h fill %0d",
                                     rsps_seen, rsp_ch.result_code, rsp_ch.out_tag,
                                     rsp_ch.fill_count));
            end else begin
               rsp_type exp_rsp;
               exp_rsp = expected_rsps.pop_front();
               if (rsp_ch.result_code !== exp_rsp.code || rsp_ch.out_tag !== exp_rsp.tag ||
                   rsp_ch.fill_count !== exp_rsp.fill) begin
                  log_failure($sformatf({"response %0d: expected code %0d tag %h fill %0d, ",
                                         "got code %0d tag %h fill %0d"}, rsps_seen,
                                        exp_rsp.code, exp_rsp.tag, exp_rsp.fill,
                                        rsp_ch.result_code, rsp_ch.out_tag, rsp_ch.fill_count));
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Empty extract, a full fill with ties and extremes, a rejected insert, partial drain.
   task automatic test_directed();
      logic [TAG_BITS-1:0] tag;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_item(CMD_EXTRACT, '1, '1);
      for (int i = 0; i < CAPACITY; i++) begin
         tag = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
         send_item(CMD_INSERT, FILL_KEYS[(CAPACITY - 1 - i) * KEY_BITS +: KEY_BITS], tag);
      end
      send_item(CMD_INSERT, 8'd42, $urandom);
      for (int i = 0; i < 6; i++) send_item(CMD_EXTRACT, KEY_BITS'($urandom), $urandom);
      wait_for_results();
   endtask

   // Hold the response side off while items keep coming, so the input stalls.
   task automatic test_fill_stall(input int n);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = HOLD_CYCLES;
      for (int i = 0; i < n; i++) begin
         send_item(($urandom_range(99) < 60) ? CMD_INSERT : CMD_EXTRACT,
                   KEY_BITS'($urandom), $urandom);
      end
      wait_for_results();
   endtask

   // Bursts that lean toward filling or draining or stay balanced, with keys from a few distributions.
   task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
      int                  burst_len;
      int                  insert_pct;
      int                  key_mode;
      int                  sent;
      logic [KEY_BITS-1:0] key;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < n) begin
         burst_len = $urandom_range(40, 1);
         case ($urandom_range(2))
            0: insert_pct = 90;
            1: insert_pct = 50;
            default: insert_pct = 10;
         endcase
         key_mode = $urandom_range(3);
         for (int i = 0; i < burst_len && sent < n; i++) begin
            case (key_mode)
               0: key = KEY_BITS'($urandom_range(3));
               1: key = KEY_BITS'($urandom_range(1) ? $urandom_range(255, 252)
                                                    : $urandom_range(3));
               default: key = KEY_BITS'($urandom);
            endcase
            send_item(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT,
                      key, $urandom);
            sent++;
         end
      end
      wait_for_results();
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_INSERT;
      req_ch.priority_req = '0;
      req_ch.record_tag   = '0;
      heap_size      = 0;
      hold_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      rsps_seen      = 0;
      fail_count     = 0;
      n_inserted     = 0;
      n_full         = 0;
      n_extracted    = 0;
      n_empty        = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_stall(30);
      test_random_phase(440, 0, 0);
      test_random_phase(430, 85, 0);
      test_random_phase(430, 0, 85);
      test_random_phase(440, 23, 23);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         log_failure($sformatf("%0d responses never arrived", expected_rsps.size()));
      end
      $display("Sent %0d items: %0d inserted, %0d rejected full, %0d extracted, %0d on empty.",
               items_sent, n_inserted, n_full, n_extracted, n_empty);
      $display("Covered tie-heavy fills, a long response hold-off and four idle/stall mixes.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d failures", fail_count);
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Timed out after %0d items and %0d responses", items_sent, rsps_seen);
      $display("Mismatches found");
      $finish;
   end

endmodule
